@@ design/dsl_pkg.sv @@
// shared types and constants for the dense sigmoid layer trainer
`timescale 1ns / 1ps
package dsl_pkg;

  localparam logic [1:0] MODE_LOAD_W = 2'd0;
  localparam logic [1:0] MODE_LOAD_B = 2'd1;
  localparam logic [1:0] MODE_ACT    = 2'd2;
  localparam logic [1:0] MODE_ERR    = 2'd3;

  localparam logic [1:0] CFG_LR    = 2'd0;
  localparam logic [1:0] CFG_N_IN  = 2'd1;
  localparam logic [1:0] CFG_N_OUT = 2'd2;

  localparam logic KIND_ACT = 1'b0;
  localparam logic KIND_ERR = 1'b1;

  localparam int ONE_Q12 = 4096;

  typedef logic signed [15:0] q12_t;

  typedef logic [31:0] exp_tab_t [16];
  localparam exp_tab_t EXP_NEG_Q16 = '{
    32'd65520, 32'd65504, 32'd65472, 32'd65408, 32'd65280, 32'd65026, 32'd64520,
    32'd63520, 32'd61565, 32'd57835, 32'd51039, 32'd39750, 32'd24109, 32'd8869,
    32'd1200, 32'd22};

  // q16 exp(-t), one factor per set bit of t, elaboration only
  function automatic longint sig_exp(input longint t);
    longint e;
    e = 65536;
    for (int b = 0; b < 16; b++) begin
      if (t[b]) e = (e * longint'(EXP_NEG_Q16[b]) + 32768) >>> 16;
    end
    return e;
  endfunction

  // saturate a wide signed value to q4.12
  function automatic q12_t sat16(input logic signed [47:0] v);
    if (v > 48'sd32767) sat16 = 16'sh7fff;
    else if (v < -48'sd32768) sat16 = 16'sh8000;
    else sat16 = v[15:0];
  endfunction

endpackage

@@ design/dense_sigmoid_layer_trainer.sv @@
// dense sigmoid layer with backpropagation on one shared multiply-accumulate unit
`timescale 1ns / 1ps
//  channel  ports                                            handshake
//  request  in_mode in_input_index in_output_index in_value  start high, busy low
//           in_last
//  result   out_kind out_position out_result_value           out_valid, one cycle
//           out_final_res
//  config   cfg_we cfg_index cfg_data                        cfg_we, any cycle idle
//
//  loads and elements without last leave busy low. a forward pass keeps busy high
//  as it reads, accumulates and emits per output, a backward pass as it forms
//  deltas, back-projects, updates weights and biases, on the single mac and the
//  one-port weight memory. each result shows the cycle after its emit state.
//  rst_n is synchronous; biases, output activations and deltas clear on reset, the
//  weight memory, input activations and error terms do not. results cannot be
//  stalled and each shows once.
module dense_sigmoid_layer_trainer import dsl_pkg::*; #(
  parameter int MAX_INPUTS = 16,
  parameter int MAX_OUTPUTS = 16,
  parameter int SIGMOID_TABLE_DEPTH = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_mode,
  input  logic [3:0]  in_input_index,
  input  logic [3:0]  in_output_index,
  input  logic signed [15:0] in_value,
  input  logic        in_last,
  output logic        out_valid,
  output logic        out_kind,
  output logic [3:0]  out_position,
  output logic signed [15:0] out_result_value,
  output logic        out_final_res,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);

  localparam int IW = (MAX_INPUTS > 1) ? $clog2(MAX_INPUTS) : 1;
  localparam int OW = (MAX_OUTPUTS > 1) ? $clog2(MAX_OUTPUTS) : 1;
  localparam int CW = $clog2(MAX_INPUTS + 1) > $clog2(MAX_OUTPUTS + 1) ?
                      $clog2(MAX_INPUTS + 1) : $clog2(MAX_OUTPUTS + 1);
  localparam int TW = $clog2(SIGMOID_TABLE_DEPTH);
  localparam int WD = MAX_INPUTS * MAX_OUTPUTS;
  localparam int WAW = (WD > 1) ? $clog2(WD) : 1;

  // sequencer states
  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_FRD  = 4'd1;  // forward: read weight
  localparam logic [3:0] S_FMAC = 4'd2;  // forward: accumulate
  localparam logic [3:0] S_FOUT = 4'd3;  // forward: bias, table, emit
  localparam logic [3:0] S_D1   = 4'd4;  // delta: o*(1-o)
  localparam logic [3:0] S_D2   = 4'd5;  // delta: times error
  localparam logic [3:0] S_BRD  = 4'd6;  // back-projection: read weight
  localparam logic [3:0] S_BMAC = 4'd7;
  localparam logic [3:0] S_BOUT = 4'd8;
  localparam logic [3:0] S_URD  = 4'd9;  // weight update: read
  localparam logic [3:0] S_UM1  = 4'd10; // lr*a
  localparam logic [3:0] S_UM2  = 4'd11; // times delta, write back
  localparam logic [3:0] S_BU   = 4'd12; // bias update

  logic [3:0] state_r, state_nxt;

  // configuration
  logic [11:0] lr_r;
  logic [4:0]  n_in_cfg_r, n_out_cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= 12'd410;
      n_in_cfg_r <= 5'd16;
      n_out_cfg_r <= 5'd16;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LR:    lr_r <= cfg_data;
        CFG_N_IN:  n_in_cfg_r <= cfg_data[4:0];
        CFG_N_OUT: n_out_cfg_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // counts clamped to [1, max]
  logic [CW-1:0] n_in, n_out;
  always_comb begin
    if (n_in_cfg_r == 5'd0) n_in = CW'(1);
    else if (32'(n_in_cfg_r) > MAX_INPUTS) n_in = CW'(MAX_INPUTS);
    else n_in = CW'(n_in_cfg_r);
    if (n_out_cfg_r == 5'd0) n_out = CW'(1);
    else if (32'(n_out_cfg_r) > MAX_OUTPUTS) n_out = CW'(MAX_OUTPUTS);
    else n_out = CW'(n_out_cfg_r);
  end

  // sigmoid table, every entry fixed at elaboration
  logic [12:0] sig_rom [SIGMOID_TABLE_DEPTH];
  for (genvar k = 0; k < SIGMOID_TABLE_DEPTH; k++) begin : g_sig
    localparam longint X = -32768 + (longint'(k) * 65536) / SIGMOID_TABLE_DEPTH;
    localparam longint E = sig_exp((X < 0) ? -X : X);
    localparam longint D = 65536 + E;
    localparam longint NUM = (X < 0) ? E * ONE_Q12 : 64'sd65536 * ONE_Q12;
    localparam logic [12:0] V = 13'((NUM + D / 2) / D);
    assign sig_rom[k] = V;
  end

  // small stores in flip-flops, read at the sequencer's index
  q12_t bias_r [MAX_OUTPUTS];
  q12_t act_in_r [MAX_INPUTS];
  q12_t act_out_r [MAX_OUTPUTS];
  q12_t err_r [MAX_OUTPUTS];
  q12_t delta_r [MAX_OUTPUTS];

  // weight memory, one port, registered read
  q12_t wmem [WD];
  q12_t wrd_r;
  logic         wwe;
  logic [WAW-1:0] waddr;
  q12_t wwd;
  always_ff @(posedge clk) begin
    if (wwe) wmem[waddr] <= wwd;
    wrd_r <= wmem[waddr];
  end

  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt;
  logic signed [47:0] acc_r, acc_nxt;
  logic signed [31:0] tmp_r, tmp_nxt;  // first product of a two-step multiply
  logic out_valid_r, out_kind_r, out_final_r;
  logic [3:0] out_pos_r;
  q12_t out_val_r;

  logic accept;
  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);

  logic [IW-1:0] ii;
  logic [OW-1:0] jj;
  assign ii = i_r[IW-1:0];
  assign jj = j_r[OW-1:0];

  // one shared multiplier
  logic signed [31:0] mul_a, mul_b;
  logic signed [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic in_ii_ok, in_oi_ok;
  assign in_ii_ok = 32'(in_input_index) < MAX_INPUTS;
  assign in_oi_ok = 32'(in_output_index) < MAX_OUTPUTS;

  logic signed [47:0] zsum;
  logic [TW-1:0] tidx;
  logic signed [47:0] zoff;
  assign zsum = (acc_r >>> 12) + 48'(bias_r[jj]);
  assign zoff = zsum + 48'sd32768;
  always_comb begin
    if (zsum < -48'sd32768) tidx = '0;
    else if (zsum >= 48'sd32768) tidx = TW'(SIGMOID_TABLE_DEPTH - 1);
    else tidx = TW'((zoff * SIGMOID_TABLE_DEPTH) >>> 16);
  end

  logic last_i, last_j;
  assign last_i = (i_r + CW'(1) == n_in);
  assign last_j = (j_r + CW'(1) == n_out);

  logic sout;  // emit request this cycle
  logic skind, sfinal;
  logic [3:0] spos;
  q12_t sval;

  always_comb begin
    state_nxt = state_r;
    i_nxt = i_r;
    j_nxt = j_r;
    acc_nxt = acc_r;
    tmp_nxt = tmp_r;
    mul_a = '0;
    mul_b = '0;
    wwe = 1'b0;
    waddr = WAW'(ii) * WAW'(MAX_OUTPUTS) + WAW'(jj);
    wwd = wrd_r;
    sout = 1'b0;
    skind = KIND_ACT;
    spos = 4'(j_r);
    sfinal = 1'b0;
    sval = '0;
    unique case (state_r)
      S_IDLE: begin
        i_nxt = '0;
        j_nxt = '0;
        acc_nxt = '0;
        if (accept && in_mode == MODE_LOAD_W && in_ii_ok && in_oi_ok) begin
          wwe = 1'b1;
          waddr = WAW'(in_input_index) * WAW'(MAX_OUTPUTS) + WAW'(in_output_index);
          wwd = in_value;
        end
        if (accept && in_last && in_mode == MODE_ACT) state_nxt = S_FRD;
        if (accept && in_last && in_mode == MODE_ERR) state_nxt = S_D1;
      end
      S_FRD: state_nxt = S_FMAC;
      S_FMAC: begin
        mul_a = 32'(act_in_r[ii]);
        mul_b = 32'(wrd_r);
        acc_nxt = acc_r + 48'(mul_p);
        if (last_i) state_nxt = S_FOUT;
        else begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_FRD;
        end
      end
      S_FOUT: begin
        sout = 1'b1;
        skind = KIND_ACT;
        spos = 4'(j_r);
        sval = q12_t'(sig_rom[tidx]);
        sfinal = last_j;
        acc_nxt = '0;
        i_nxt = '0;
        j_nxt = j_r + CW'(1);
        state_nxt = last_j ? S_IDLE : S_FRD;
      end
      S_D1: begin
        mul_a = 32'(act_out_r[jj]);
        mul_b = 32'sd4096 - 32'(act_out_r[jj]);
        tmp_nxt = mul_p[31:0];
        state_nxt = S_D2;
      end
      S_D2: begin
        mul_a = tmp_r;
        mul_b = 32'(err_r[jj]);
        if (last_j) begin
          j_nxt = '0;
          state_nxt = S_BRD;
        end else begin
          j_nxt = j_r + CW'(1);
          state_nxt = S_D1;
        end
      end
      S_BRD: state_nxt = S_BMAC;
      S_BMAC: begin
        mul_a = 32'(delta_r[jj]);
        mul_b = 32'(wrd_r);
        acc_nxt = acc_r + 48'(mul_p);
        if (last_j) state_nxt = S_BOUT;
        else begin
          j_nxt = j_r + CW'(1);
          state_nxt = S_BRD;
        end
      end
      S_BOUT: begin
        sout = 1'b1;
        skind = KIND_ERR;
        spos = 4'(i_r);
        sval = sat16(acc_r >>> 12);
        sfinal = last_i;
        acc_nxt = '0;
        j_nxt = '0;
        if (last_i) begin
          i_nxt = '0;
          state_nxt = S_URD;
        end else begin
          i_nxt = i_r + CW'(1);
          state_nxt = S_BRD;
        end
      end
      S_URD: state_nxt = S_UM1;
      S_UM1: begin
        mul_a = {20'd0, lr_r};
        mul_b = 32'(act_in_r[ii]);
        tmp_nxt = mul_p[31:0];
        state_nxt = S_UM2;
      end
      S_UM2: begin
        mul_a = tmp_r;
        mul_b = 32'(delta_r[jj]);
        wwe = 1'b1;
        wwd = sat16(48'(wrd_r) + 48'(mul_p >>> 24));
        if (last_j) begin
          j_nxt = '0;
          if (last_i) state_nxt = S_BU;
          else begin
            i_nxt = i_r + CW'(1);
            state_nxt = S_URD;
          end
        end else begin
          j_nxt = j_r + CW'(1);
          state_nxt = S_URD;
        end
      end
      S_BU: begin
        mul_a = {20'd0, lr_r};
        mul_b = 32'(delta_r[jj]);
        if (last_j) state_nxt = S_IDLE;
        else j_nxt = j_r + CW'(1);
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      out_valid_r <= 1'b0;
      for (int k = 0; k < MAX_OUTPUTS; k++) begin
        bias_r[k] <= '0;
        act_out_r[k] <= '0;
        delta_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      out_valid_r <= sout;
      if (accept && in_mode == MODE_LOAD_B && in_oi_ok) bias_r[OW'(in_output_index)] <= in_value;
      if (state_r == S_FOUT) act_out_r[jj] <= sval;
      if (state_r == S_D2) delta_r[jj] <= sat16(48'(mul_p >>> 24));
      if (state_r == S_BU) bias_r[jj] <= sat16(48'(bias_r[jj]) + 48'(mul_p >>> 12));
    end
  end

  always_ff @(posedge clk) begin
    i_r <= i_nxt;
    j_r <= j_nxt;
    acc_r <= acc_nxt;
    tmp_r <= tmp_nxt;
    if (accept && in_mode == MODE_ACT && in_ii_ok) act_in_r[IW'(in_input_index)] <= in_value;
    if (accept && in_mode == MODE_ERR && in_oi_ok) err_r[OW'(in_output_index)] <= in_value;
    out_kind_r <= skind;
    out_pos_r <= spos;
    out_val_r <= sval;
    out_final_r <= sfinal;
  end

  assign out_valid = out_valid_r;
  assign out_kind = out_kind_r;
  assign out_position = out_pos_r;
  assign out_result_value = out_val_r;
  assign out_final_res = out_final_r;

endmodule

@@ dv/dense_sigmoid_layer_trainer_tb.sv @@
// self-checking testbench for the dense sigmoid layer trainer
`timescale 1ns / 1ps
module dense_sigmoid_layer_trainer_tb import dsl_pkg::*; ();

  // index with no register behind it, writes there must change nothing
  localparam logic [1:0] CFG_SPARE = 2'd3;
  // settle time before a register write, covers a full backward pass
  localparam int SETTLE_CYCLES = 1400;

  typedef struct packed {
    logic       kind;
    logic [3:0] position;
    q12_t       value;
    logic       final_res;
  } layer_result_t;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic [1:0]  in_mode;
  logic [3:0]  in_input_index;
  logic [3:0]  in_output_index;
  logic signed [15:0] in_value;
  logic        in_last;
  logic        out_valid;
  logic        out_kind;
  logic [3:0]  out_position;
  logic signed [15:0] out_result_value;
  logic        out_final_res;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [11:0] cfg_data;

  dense_sigmoid_layer_trainer DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_input_index(in_input_index),
    .in_output_index(in_output_index), .in_value(in_value), .in_last(in_last),
    .out_valid(out_valid), .out_kind(out_kind), .out_position(out_position),
    .out_result_value(out_result_value), .out_final_res(out_final_res),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // predicted layer state
  q12_t        weights_m [16][16];
  q12_t        biases_m [16];
  q12_t        acts_in_m [16];
  q12_t        acts_out_m [16];
  q12_t        errors_m [16];
  q12_t        deltas_m [16];
  logic [12:0] sigmoid_rom [256];
  logic [11:0] lr_m;
  logic [4:0]  n_in_m;
  logic [4:0]  n_out_m;

  layer_result_t pending_results [$];
  int            error_count;
  int            request_count;

  // clock, 20 ns period
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // sigmoid table over [-8,8), integer exp from q16 factors
  function automatic void build_sigmoid_rom();
    longint x, t, e, d, num;
    logic [31:0] factors [16];
    factors = '{65520, 65504, 65472, 65408, 65280, 65026, 64520, 63520,
                61565, 57835, 51039, 39750, 24109, 8869, 1200, 22};
    for (int k = 0; k < 256; k++) begin
      x = -32768 + (longint'(k) * 65536) / 256;
      t = (x < 0) ? -x : x;
      e = 65536;
      for (int b = 0; b < 16; b++) begin
        if (t[b]) e = (e * longint'(factors[b]) + 32768) >>> 16;
      end
      d = 65536 + e;
      num = (x < 0) ? e * 4096 : 65536 * 4096;
      sigmoid_rom[k] = 13'((num + d / 2) / d);
    end
  endfunction

  function automatic q12_t clip_q12(input longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return q12_t'(v);
  endfunction

  function automatic int used_count(input logic [4:0] v);
    if (v == 0) return 1;
    if (v > 16) return 16;
    return int'(v);
  endfunction

  function automatic q12_t sigmoid_of(input longint z);
    int idx;
    if (z < -32768) idx = 0;
    else if (z >= 32768) idx = 255;
    else idx = int'(((z + 32768) * 256) >>> 16);
    return q12_t'({3'b000, sigmoid_rom[idx]});
  endfunction

  // layer update for one accepted request, queues the results it causes
  task automatic predict_layer(input logic [1:0] mode, input logic [3:0] ii,
                               input logic [3:0] oi, input q12_t v, input logic last);
    int n_in, n_out;
    longint acc, o, u;
    layer_result_t r;
    n_in = used_count(n_in_m);
    n_out = used_count(n_out_m);
    case (mode)
      MODE_LOAD_W: weights_m[ii][oi] = v;
      MODE_LOAD_B: biases_m[oi] = v;
      MODE_ACT: begin
        acts_in_m[ii] = v;
        if (last) begin
          for (int j = 0; j < n_out; j++) begin
            acc = 0;
            for (int i = 0; i < n_in; i++)
              acc += longint'(acts_in_m[i]) * longint'(weights_m[i][j]);
            acc = (acc >>> 12) + longint'(biases_m[j]);
            acts_out_m[j] = sigmoid_of(acc);
            r.kind = KIND_ACT;
            r.position = 4'(j);
            r.value = acts_out_m[j];
            r.final_res = (j + 1 == n_out);
            pending_results.push_back(r);
          end
        end
      end
      default: begin
        errors_m[oi] = v;
        if (last) begin
          for (int j = 0; j < n_out; j++) begin
            o = longint'(acts_out_m[j]);
            deltas_m[j] = clip_q12((o * (ONE_Q12 - o) * longint'(errors_m[j])) >>> 24);
          end
          // back-projection uses the weights before the update
          for (int i = 0; i < n_in; i++) begin
            acc = 0;
            for (int j = 0; j < n_out; j++)
              acc += longint'(deltas_m[j]) * longint'(weights_m[i][j]);
            r.kind = KIND_ERR;
            r.position = 4'(i);
            r.value = clip_q12(acc >>> 12);
            r.final_res = (i + 1 == n_in);
            pending_results.push_back(r);
          end
          for (int i = 0; i < n_in; i++)
            for (int j = 0; j < n_out; j++) begin
              u = longint'(lr_m) * longint'(acts_in_m[i]) * longint'(deltas_m[j]);
              weights_m[i][j] = clip_q12(longint'(weights_m[i][j]) + (u >>> 24));
            end
          for (int j = 0; j < n_out; j++) begin
            u = longint'(lr_m) * longint'(deltas_m[j]);
            biases_m[j] = clip_q12(longint'(biases_m[j]) + (u >>> 12));
          end
        end
      end
    endcase
  endtask

  // result checker, results show for one cycle only
  always @(posedge clk) begin
    layer_result_t exp_r;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: kind %0d position %0d value %0d final %0d",
                 $time, out_kind, out_position, out_result_value, out_final_res);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (out_kind !== exp_r.kind) begin
          $display("%0t kind mismatch: expected %0d actual %0d", $time, exp_r.kind,
                   out_kind);
          error_count++;
        end
        if (out_position !== exp_r.position) begin
          $display("%0t position mismatch: expected %0d actual %0d", $time,
                   exp_r.position, out_position);
          error_count++;
        end
        if (out_result_value !== exp_r.value) begin
          $display("%0t value mismatch at position %0d: expected %0d actual %0d", $time,
                   exp_r.position, exp_r.value, out_result_value);
          error_count++;
        end
        if (out_final_res !== exp_r.final_res) begin
          $display("%0t final flag mismatch: expected %0d actual %0d", $time,
                   exp_r.final_res, out_final_res);
          error_count++;
        end
      end
    end
  end

  // one request, held until accepted at an edge with busy low
  task automatic send_request(input logic [1:0] mode, input logic [3:0] ii,
                              input logic [3:0] oi, input q12_t v, input logic last);
    start <= 1'b1;
    in_mode <= mode;
    in_input_index <= ii;
    in_output_index <= oi;
    in_value <= v;
    in_last <= last;
    do @(posedge clk); while (busy);
    predict_layer(mode, ii, oi, v, last);
    request_count++;
  endtask

  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // block idle: nothing expected, then long enough for any update to finish
  task automatic wait_layer_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    case (idx)
      CFG_LR:    lr_m = data;
      CFG_N_IN:  n_in_m = data[4:0];
      CFG_N_OUT: n_out_m = data[4:0];
      default: ;
    endcase
  endtask

  task automatic set_layer(input logic [11:0] lr, input logic [11:0] nin,
                           input logic [11:0] nout);
    wait_layer_idle();
    write_reg(CFG_LR, lr);
    write_reg(CFG_N_IN, nin);
    write_reg(CFG_N_OUT, nout);
    cfg_we <= 1'b0;
  endtask

  function automatic q12_t random_value();
    if ($urandom_range(0, 1)) return q12_t'($urandom_range(0, 65535));
    return q12_t'(int'($urandom_range(0, 8191)) - 4096);
  endfunction

  // weights of the first eight neurons, every activation and error, written
  // before any pass reads them; passes then use at most eight neurons
  task automatic test_store_fill();
    for (int i = 0; i < 16; i++)
      for (int j = 0; j < 8; j++)
        send_request(MODE_LOAD_W, 4'(i), 4'(j), q12_t'(int'($urandom_range(0, 4095)) - 2048),
                     1'b0);
    for (int i = 0; i < 16; i++)
      send_request(MODE_ACT, 4'(i), 4'($urandom_range(0, 15)), random_value(), 1'b0);
    for (int j = 0; j < 16; j++)
      send_request(MODE_ERR, 4'($urandom_range(0, 15)), 4'(j), random_value(), 1'b0);
  endtask

  // extremes, last on loads, passes pushed past the table range
  task automatic test_directed();
    set_layer(12'd410, 12'd16, 12'd8);
    send_request(MODE_LOAD_B, 4'd0, 4'd0, 16'sh7fff, 1'b1);
    send_request(MODE_LOAD_B, 4'd15, 4'd15, 16'sh8000, 1'b0);
    send_request(MODE_LOAD_W, 4'd15, 4'd0, 16'sh7fff, 1'b1);
    send_request(MODE_LOAD_W, 4'd0, 4'd15, 16'sh8000, 1'b0);
    send_request(MODE_ACT, 4'd0, 4'd0, 16'sh7fff, 1'b0);
    send_request(MODE_ACT, 4'd15, 4'd0, 16'sh8000, 1'b1);
    send_request(MODE_ERR, 4'd0, 4'd0, 16'sh7fff, 1'b0);
    send_request(MODE_ERR, 4'd0, 4'd15, 16'sh8000, 1'b1);
    send_request(MODE_ACT, 4'd3, 4'd9, 16'sh0000, 1'b1);
    send_request(MODE_ERR, 4'd7, 4'd2, 16'sh1000, 1'b1);
    send_request(MODE_LOAD_B, 4'd0, 4'd5, 16'sh0000, 1'b0);
    send_request(MODE_ACT, 4'd8, 4'd0, 16'shf000, 1'b1);
    send_request(MODE_ERR, 4'd0, 4'd5, 16'shffff, 1'b1);
  endtask

  // well-formed sequences with random content, plus loose requests as noise
  task automatic test_random(input int requests, input int quiet_tail);
    int n, first_count;
    logic [1:0] m;
    first_count = request_count;
    while (request_count - first_count < requests) begin
      if (request_count - first_count < requests - quiet_tail &&
          $urandom_range(0, 3) == 0)
        idle_sender($urandom_range(1, 15));
      if ($urandom_range(0, 9) < 7) begin
        m = $urandom_range(0, 1) ? MODE_ACT : MODE_ERR;
        n = $urandom_range(0, 4);
        for (int k = 0; k < n; k++)
          send_request(m, 4'($urandom), 4'($urandom), random_value(), 1'b0);
        send_request(m, 4'($urandom), 4'($urandom), random_value(), 1'b1);
      end else begin
        send_request(2'($urandom), 4'($urandom), 4'($urandom), random_value(),
                     1'($urandom));
      end
    end
  endtask

  task automatic test_config_sweep();
    set_layer(12'd0, 12'd0, 12'd0);
    test_random(10, 0);
    set_layer(12'd4095, 12'd31, 12'd1);
    test_random(10, 0);
    wait_layer_idle();
    write_reg(CFG_LR, 12'd2000);
    write_reg(CFG_N_IN, 12'd1);
    write_reg(CFG_N_OUT, 12'd8);
    write_reg(CFG_SPARE, 12'hfff);
    cfg_we <= 1'b0;
    test_random(10, 0);
    set_layer(12'($urandom), 12'($urandom_range(0, 31)), 12'($urandom_range(0, 8)));
    test_random(10, 0);
    set_layer(12'd410, 12'd16, 12'd8);
    test_random(20, 8);
  endtask

  // timeout
  initial begin
    #50_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    error_count = 0;
    request_count = 0;
    build_sigmoid_rom();
    for (int i = 0; i < 16; i++) begin
      biases_m[i] = '0;
      acts_out_m[i] = '0;
      deltas_m[i] = '0;
      acts_in_m[i] = '0;
      errors_m[i] = '0;
      for (int j = 0; j < 16; j++) weights_m[i][j] = '0;
    end
    lr_m = 12'd410;
    n_in_m = 5'd16;
    n_out_m = 5'd16;
    rst_n = 1'b0;
    start = 1'b0;
    in_mode = MODE_LOAD_W;
    in_input_index = '0;
    in_output_index = '0;
    in_value = '0;
    in_last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_LR;
    cfg_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_store_fill();
    test_directed();
    test_config_sweep();
    // drain the last pass, then let any update finish
    wait_layer_idle();
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
